/* hw/rtl/i2cmbe_pkg.sv */
`timescale 1ns / 1ps

package i2cmbe_pkg;

  // Command codes on the kind field
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  // Running command, one-hot
  typedef enum logic [4:0] {
    CMD_IDLE  = 5'b00001,
    CMD_START = 5'b00010,
    CMD_STOP  = 5'b00100,
    CMD_WRITE = 5'b01000,
    CMD_READ  = 5'b10000
  } cmd_t;

  // Last step index of each sequence
  localparam logic [4:0] START_LAST = 5'd3;
  localparam logic [4:0] STOP_LAST  = 5'd2;
  localparam logic [4:0] BYTE_LAST  = 5'd27;

  // Step indices inside the byte sequences
  localparam logic [4:0] BITS_END  = 5'd24;  // write: bit steps are below this
  localparam logic [4:0] ACK_REL   = 5'd24;
  localparam logic [4:0] ACK_SCLH  = 5'd25;
  localparam logic [4:0] ACK_SAMP  = 5'd26;
  localparam logic [4:0] RD_ACK    = 5'd25;
  localparam logic [4:0] RD_SCLH   = 5'd26;

  // Phase within one bit slot (three steps per bit)
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  function automatic cmd_t kind_to_cmd(input logic [2:0] kind);
    cmd_t c;
    unique case (kind)
      KIND_START: c = CMD_START;
      KIND_STOP:  c = CMD_STOP;
      KIND_WRITE: c = CMD_WRITE;
      KIND_READ:  c = CMD_READ;
      default:    c = CMD_IDLE;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/i2c_master_byte_engine.sv */
`timescale 1ns / 1ps

// I2C master engine stepped one bus time step per input item. An item carries a
// command kind (tick, start, stop, write byte, read byte), the byte to send, the
// acknowledge level to send after a read, and the sampled SDA level. A command
// arriving while idle starts its sequence and takes its first pin step on that
// same item; each later item takes the next step. Start runs 4 steps, stop 3,
// write byte and read byte 28 each (bytes go MSB first, read bytes are sampled
// MSB first). A command arriving while busy is dropped and flagged as rejected;
// the running sequence still advances. Each item yields one result item with the
// SCL/SDA levels after the step, busy/done flags, the last read byte and the last
// write acknowledge. Throughput is one item per clock: the step logic sits
// between the engine state and a single result register, and the input side is
// stalled only while that result register is full and stalled downstream.
// The result is offered in the cycle after the item is accepted.

module i2c_master_byte_engine (
  input  logic       clk,
  input  logic       rst,
  // input items
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [7:0] write_byte,
  input  logic       ack_level,
  input  logic       sda_in,
  // result items
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_data,
  output logic       ack_seen,
  output logic       rejected
);

  // Engine state
  i2cmbe_pkg::cmd_t active_command;
  logic [4:0]       step_index;
  logic [1:0]       phase;
  logic [7:0]       shift_reg;
  logic             ack_out_hold;
  logic             scl_reg;
  logic             sda_reg;
  logic             ack_reg;
  logic [7:0]       read_hold;

  i2cmbe_pkg::cmd_t active_command_next;
  logic [4:0]       step_index_next;
  logic [1:0]       phase_next;
  logic [7:0]       shift_reg_next;
  logic             ack_out_hold_next;
  logic             scl_reg_next;
  logic             sda_reg_next;
  logic             ack_reg_next;
  logic [7:0]       read_hold_next;
  logic             done_next;
  logic             rejected_next;

  // Working view of the step being taken
  i2cmbe_pkg::cmd_t kind_cmd;
  i2cmbe_pkg::cmd_t cmd;
  logic [4:0]       k;
  logic [1:0]       ph;
  logic [1:0]       ph_adv;
  logic [7:0]       sh;
  logic             ack_hold;
  logic             last;

  logic accept;

  // Result register frees up when empty or being taken this cycle
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign kind_cmd = i2cmbe_pkg::kind_to_cmd(kind);

  always_comb begin
    // Launch a new command when idle, else continue the running one
    rejected_next = 1'b0;
    cmd      = active_command;
    k        = step_index;
    ph       = phase;
    sh       = shift_reg;
    ack_hold = ack_out_hold;
    if (active_command == i2cmbe_pkg::CMD_IDLE) begin
      if (kind_cmd != i2cmbe_pkg::CMD_IDLE) begin
        cmd = kind_cmd;
        k   = 5'd0;
        ph  = i2cmbe_pkg::PH_A;
        if (kind_cmd == i2cmbe_pkg::CMD_WRITE) begin
          sh = write_byte;
        end
        if (kind_cmd == i2cmbe_pkg::CMD_READ) begin
          sh       = 8'd0;
          ack_hold = ack_level;
        end
      end
    end else if (kind_cmd != i2cmbe_pkg::CMD_IDLE) begin
      rejected_next = 1'b1;
    end

    ph_adv = (ph == i2cmbe_pkg::PH_C) ? i2cmbe_pkg::PH_A : ph + 2'd1;

    scl_reg_next      = scl_reg;
    sda_reg_next      = sda_reg;
    ack_reg_next      = ack_reg;
    shift_reg_next    = sh;
    ack_out_hold_next = ack_hold;
    phase_next        = ph;
    last              = 1'b0;

    unique case (cmd)
      i2cmbe_pkg::CMD_IDLE: begin
      end
      i2cmbe_pkg::CMD_START: begin
        // SDA=1, SCL=1, SDA=0, SCL=0
        last = (k == i2cmbe_pkg::START_LAST);
        case (k[1:0])
          2'd0:    sda_reg_next = 1'b1;
          2'd1:    scl_reg_next = 1'b1;
          2'd2:    sda_reg_next = 1'b0;
          default: scl_reg_next = 1'b0;
        endcase
      end
      i2cmbe_pkg::CMD_STOP: begin
        // SDA=0, SCL=1, SDA=1
        last = (k == i2cmbe_pkg::STOP_LAST);
        case (k[1:0])
          2'd0:    sda_reg_next = 1'b0;
          2'd1:    scl_reg_next = 1'b1;
          default: sda_reg_next = 1'b1;
        endcase
      end
      i2cmbe_pkg::CMD_WRITE: begin
        last = (k == i2cmbe_pkg::BYTE_LAST);
        if (k < i2cmbe_pkg::BITS_END) begin
          phase_next = ph_adv;
          case (ph)
            i2cmbe_pkg::PH_A: begin
              sda_reg_next   = sh[7];
              shift_reg_next = {sh[6:0], 1'b0};
            end
            i2cmbe_pkg::PH_B: scl_reg_next = 1'b1;
            default:          scl_reg_next = 1'b0;
          endcase
        end else if (k == i2cmbe_pkg::ACK_REL) begin
          sda_reg_next = 1'b1;
        end else if (k == i2cmbe_pkg::ACK_SCLH) begin
          scl_reg_next = 1'b1;
        end else if (k == i2cmbe_pkg::ACK_SAMP) begin
          ack_reg_next = sda_in;
        end else begin
          scl_reg_next = 1'b0;
        end
      end
      i2cmbe_pkg::CMD_READ: begin
        last = (k == i2cmbe_pkg::BYTE_LAST);
        if (k == 5'd0) begin
          sda_reg_next = 1'b1;  // release SDA, bit slots start on the next step
          phase_next   = i2cmbe_pkg::PH_A;
        end else if (k <= i2cmbe_pkg::BITS_END) begin
          phase_next = ph_adv;
          case (ph)
            i2cmbe_pkg::PH_A: scl_reg_next   = 1'b1;
            i2cmbe_pkg::PH_B: shift_reg_next = {sh[6:0], sda_in};
            default:          scl_reg_next   = 1'b0;
          endcase
        end else if (k == i2cmbe_pkg::RD_ACK) begin
          sda_reg_next = ack_hold;
        end else if (k == i2cmbe_pkg::RD_SCLH) begin
          scl_reg_next = 1'b1;
        end else begin
          scl_reg_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    done_next           = last;
    read_hold_next      = read_hold;
    active_command_next = cmd;
    step_index_next     = step_index;
    if (cmd != i2cmbe_pkg::CMD_IDLE) begin
      if (last) begin
        if (cmd == i2cmbe_pkg::CMD_READ) begin
          read_hold_next = shift_reg_next;
        end
        active_command_next = i2cmbe_pkg::CMD_IDLE;
        step_index_next     = 5'd0;
      end else begin
        step_index_next = k + 5'd1;
      end
    end
  end

  // Engine state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_command <= i2cmbe_pkg::CMD_IDLE;
      step_index     <= 5'd0;
      phase          <= i2cmbe_pkg::PH_A;
      shift_reg      <= 8'd0;
      ack_out_hold   <= 1'b1;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      ack_reg        <= 1'b1;
      read_hold      <= 8'd0;
    end else if (accept) begin
      active_command <= active_command_next;
      step_index     <= step_index_next;
      phase          <= phase_next;
      shift_reg      <= shift_reg_next;
      ack_out_hold   <= ack_out_hold_next;
      scl_reg        <= scl_reg_next;
      sda_reg        <= sda_reg_next;
      ack_reg        <= ack_reg_next;
      read_hold      <= read_hold_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_level <= scl_reg_next;
      sda_level <= sda_reg_next;
      busy_res  <= (active_command_next != i2cmbe_pkg::CMD_IDLE);
      done_res  <= done_next;
      read_data <= read_hold_next;
      ack_seen  <= ack_reg_next;
      rejected  <= rejected_next;
    end
  end

endmodule

/* tb/i2c_master_byte_engine_chk.sv */
`timescale 1ns / 1ps

// Watches both channels of the I2C byte engine, predicts each result item and
// compares it field by field against the oldest prediction.
module i2c_master_byte_engine_chk (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] kind,
  input  logic [7:0] write_byte,
  input  logic       ack_level,
  input  logic       sda_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       scl_level,
  input  logic       sda_level,
  input  logic       busy_res,
  input  logic       done_res,
  input  logic [7:0] read_data,
  input  logic       ack_seen,
  input  logic       rejected,
  output int         fail_count,
  output int         expected_left
);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       ack;
    logic       rej;
  } bus_result_t;

  // mirror of the engine state
  i2cmbe_pkg::cmd_t run_cmd;
  logic [4:0]       step_no;
  logic [7:0]       shreg;
  logic             ack_hold;
  logic             scl_q;
  logic             sda_q;
  logic             ack_q;
  logic [7:0]       last_read;

  bus_result_t pin_q[$];
  int          n_fail;

  function automatic bus_result_t advance_bus(input logic [2:0] k, input logic [7:0] wb,
                                              input logic al, input logic sd);
    bus_result_t r;
    logic        is_cmd;
    logic [4:0]  last_step;
    logic [4:0]  j;
    logic [2:0]  slot;
    logic [1:0]  ph;
    is_cmd = (k == i2cmbe_pkg::KIND_START) || (k == i2cmbe_pkg::KIND_STOP) ||
             (k == i2cmbe_pkg::KIND_WRITE) || (k == i2cmbe_pkg::KIND_READ);
    r.rej  = 1'b0;
    r.done = 1'b0;
    if (run_cmd == i2cmbe_pkg::CMD_IDLE) begin
      if (is_cmd) begin
        step_no = '0;
        case (k)
          i2cmbe_pkg::KIND_START: run_cmd = i2cmbe_pkg::CMD_START;
          i2cmbe_pkg::KIND_STOP:  run_cmd = i2cmbe_pkg::CMD_STOP;
          i2cmbe_pkg::KIND_WRITE: begin
            run_cmd = i2cmbe_pkg::CMD_WRITE;
            shreg   = wb;
          end
          default: begin
            run_cmd  = i2cmbe_pkg::CMD_READ;
            shreg    = '0;
            ack_hold = al;
          end
        endcase
      end
    end else if (is_cmd) begin
      r.rej = 1'b1;
    end

    if (run_cmd != i2cmbe_pkg::CMD_IDLE) begin
      case (run_cmd)
        i2cmbe_pkg::CMD_START: begin
          case (step_no)
            5'd0:    sda_q = 1'b1;
            5'd1:    scl_q = 1'b1;
            5'd2:    sda_q = 1'b0;
            default: scl_q = 1'b0;
          endcase
          last_step = i2cmbe_pkg::START_LAST;
        end
        i2cmbe_pkg::CMD_STOP: begin
          case (step_no)
            5'd0:    sda_q = 1'b0;
            5'd1:    scl_q = 1'b1;
            default: sda_q = 1'b1;
          endcase
          last_step = i2cmbe_pkg::STOP_LAST;
        end
        i2cmbe_pkg::CMD_WRITE: begin
          slot = 3'(step_no / 3);
          ph   = 2'(step_no % 3);
          if (step_no < i2cmbe_pkg::BITS_END) begin
            if (ph == i2cmbe_pkg::PH_A)      sda_q = shreg[3'd7 - slot];
            else if (ph == i2cmbe_pkg::PH_B) scl_q = 1'b1;
            else                             scl_q = 1'b0;
          end else if (step_no == i2cmbe_pkg::ACK_REL) begin
            sda_q = 1'b1;
          end else if (step_no == i2cmbe_pkg::ACK_SCLH) begin
            scl_q = 1'b1;
          end else if (step_no == i2cmbe_pkg::ACK_SAMP) begin
            ack_q = sd;
          end else begin
            scl_q = 1'b0;
          end
          last_step = i2cmbe_pkg::BYTE_LAST;
        end
        default: begin
          j    = step_no - 5'd1;
          slot = 3'(j / 3);
          ph   = 2'(j % 3);
          if (step_no == 5'd0) begin
            sda_q = 1'b1;
          end else if (step_no <= i2cmbe_pkg::BITS_END) begin
            if (ph == i2cmbe_pkg::PH_A)      scl_q = 1'b1;
            else if (ph == i2cmbe_pkg::PH_B) begin
              if (sd) shreg[3'd7 - slot] = 1'b1;
            end else                         scl_q = 1'b0;
          end else if (step_no == i2cmbe_pkg::RD_ACK) begin
            sda_q = ack_hold;
          end else if (step_no == i2cmbe_pkg::RD_SCLH) begin
            scl_q = 1'b1;
          end else begin
            scl_q = 1'b0;
          end
          last_step = i2cmbe_pkg::BYTE_LAST;
        end
      endcase
      if (step_no == last_step) begin
        r.done = 1'b1;
        if (run_cmd == i2cmbe_pkg::CMD_READ) last_read = shreg;
        run_cmd = i2cmbe_pkg::CMD_IDLE;
        step_no = '0;
      end else begin
        step_no = step_no + 5'd1;
      end
    end

    r.scl   = scl_q;
    r.sda   = sda_q;
    r.busy  = (run_cmd != i2cmbe_pkg::CMD_IDLE);
    r.rdata = last_read;
    r.ack   = ack_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    bus_result_t got;
    bus_result_t want;
    if (rst) begin
      run_cmd       = i2cmbe_pkg::CMD_IDLE;
      step_no       = '0;
      shreg         = '0;
      ack_hold      = 1'b1;
      scl_q         = 1'b1;
      sda_q         = 1'b1;
      ack_q         = 1'b1;
      last_read     = '0;
      n_fail        = 0;
      pin_q.delete();
      fail_count    <= 0;
      expected_left <= 0;
    end else begin
      // result first: results are registered, so one taken now never belongs to the item accepted now
      if (out_valid && !out_stall) begin
        got.scl   = scl_level;
        got.sda   = sda_level;
        got.busy  = busy_res;
        got.done  = done_res;
        got.rdata = read_data;
        got.ack   = ack_seen;
        got.rej   = rejected;
        if (pin_q.size() == 0) begin
          $error("result item with nothing expected");
          n_fail++;
        end else begin
          want = pin_q.pop_front();
          check_field("scl_level", 8'(want.scl),  8'(got.scl));
          check_field("sda_level", 8'(want.sda),  8'(got.sda));
          check_field("busy_res",  8'(want.busy), 8'(got.busy));
          check_field("done_res",  8'(want.done), 8'(got.done));
          check_field("read_data", want.rdata,    got.rdata);
          check_field("ack_seen",  8'(want.ack),  8'(got.ack));
          check_field("rejected",  8'(want.rej),  8'(got.rej));
        end
      end
      if (in_valid && !in_stall)
        pin_q.push_back(advance_bus(kind, write_byte, ack_level, sda_in));
      expected_left <= pin_q.size();
      fail_count    <= n_fail;
    end
  end

endmodule

/* tb/i2c_master_byte_engine_tb.sv */
`timescale 1ns / 1ps

// Top of the I2C byte engine bench: clock, reset, item stimulus, result-side
// stalls and the verdict. Prediction and comparison live in the checker.
module i2c_master_byte_engine_tb;

  // no command code this high; the engine treats it as a plain tick
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int         ITEM_TARGET = 1200;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] kind = i2cmbe_pkg::KIND_TICK;
  logic [7:0] write_byte = '0;
  logic       ack_level = 1'b0;
  logic       sda_in = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_seen;
  logic       rejected;
  int         fail_count;
  int         expected_left;

  int n_items = 0;    // items accepted so far
  int n_results = 0;  // results taken so far

  always #4 clk = ~clk;

  i2c_master_byte_engine dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .write_byte (write_byte),
    .ack_level  (ack_level),
    .sda_in     (sda_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_data  (read_data),
    .ack_seen   (ack_seen),
    .rejected   (rejected)
  );

  i2c_master_byte_engine_chk chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .write_byte    (write_byte),
    .ack_level     (ack_level),
    .sda_in        (sda_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scl_level     (scl_level),
    .sda_level     (sda_level),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .read_data     (read_data),
    .ack_seen      (ack_seen),
    .rejected      (rejected),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // One bus step. An idle gap of random length comes first, except in calm stretches
  // of back-to-back items. Returns at the edge where the item is taken.
  task automatic send_item(input logic [2:0] k, input logic [7:0] wb,
                           input logic al, input logic sd);
    int gap;
    gap = (n_items % 128 < 32) ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    write_byte <= wb;
    ack_level  <= al;
    sda_in     <= sd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
  endtask

  // A whole command: the command item, then ticks to the end of its sequence.
  // sd_pat gives the SDA level sampled at each step (bit n at step n).
  // mid_kind lands on step 2, so a command there is refused; noisy sprinkles
  // random kinds over the ticks. Tick operands are random: they must be ignored.
  task automatic run_cmd(input logic [2:0] k, input logic [7:0] wb, input logic al,
                         input logic [31:0] sd_pat, input logic [2:0] mid_kind,
                         input bit noisy);
    int         len;
    logic [2:0] tk;
    len = (k == i2cmbe_pkg::KIND_START) ? int'(i2cmbe_pkg::START_LAST) + 1 :
          (k == i2cmbe_pkg::KIND_STOP)  ? int'(i2cmbe_pkg::STOP_LAST) + 1  :
                                          int'(i2cmbe_pkg::BYTE_LAST) + 1;
    send_item(k, wb, al, sd_pat[0]);
    for (int s = 1; s < len; s++) begin
      tk = i2cmbe_pkg::KIND_TICK;
      if (s == 2) tk = mid_kind;
      else if (noisy && $urandom_range(0, 15) == 0) tk = 3'($urandom_range(0, 7));
      send_item(tk, 8'($urandom), 1'($urandom), sd_pat[s]);
    end
  endtask

  // Result side: per result a stall of random length, none in calm stretches.
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = (n_results % 100 < 25) ? 0 : $urandom_range(0, 7);
      repeat (hold) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      n_results++;
    end
  end

  initial begin
    logic [2:0] k;
    logic [7:0] wb;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: idle ticks, each command, extremes of the byte and SDA,
    // commands and unused kinds while busy, unused kinds while idle
    send_item(i2cmbe_pkg::KIND_TICK, 8'hFF, 1'b1, 1'b0);
    send_item(i2cmbe_pkg::KIND_TICK, 8'h00, 1'b0, 1'b1);
    run_cmd(i2cmbe_pkg::KIND_START, 8'h00, 1'b0, 32'h0,
            i2cmbe_pkg::KIND_WRITE, 1'b0);
    run_cmd(i2cmbe_pkg::KIND_WRITE, 8'hFF, 1'b0, 32'hFFFF_FFFF,
            i2cmbe_pkg::KIND_READ, 1'b0);  // not acked
    run_cmd(i2cmbe_pkg::KIND_WRITE, 8'h00, 1'b1, 32'h0,
            KIND_UNUSED, 1'b0);  // acked
    run_cmd(i2cmbe_pkg::KIND_WRITE, 8'hA5, 1'b0, 32'h5555_5555,
            i2cmbe_pkg::KIND_TICK, 1'b0);
    run_cmd(i2cmbe_pkg::KIND_READ, 8'hFF, 1'b0, 32'hFFFF_FFFF,
            i2cmbe_pkg::KIND_STOP, 1'b0);  // reads FF, acks
    run_cmd(i2cmbe_pkg::KIND_READ, 8'h00, 1'b1, 32'h0,
            i2cmbe_pkg::KIND_START, 1'b0);  // reads 00, nacks
    run_cmd(i2cmbe_pkg::KIND_READ, 8'h5A, 1'b0, 32'h0924_9249,
            i2cmbe_pkg::KIND_TICK, 1'b0);
    run_cmd(i2cmbe_pkg::KIND_STOP, 8'h00, 1'b0, 32'h0,
            KIND_UNUSED - 3'd2, 1'b0);
    for (int u = int'(i2cmbe_pkg::KIND_READ) + 1; u <= int'(KIND_UNUSED); u++)
      send_item(3'(u), 8'($urandom), 1'($urandom), 1'($urandom));

    // random: mostly whole commands with random content, some idle noise
    while (n_items < ITEM_TARGET) begin
      k  = 3'($urandom_range(int'(i2cmbe_pkg::KIND_START), int'(i2cmbe_pkg::KIND_READ)));
      wb = ($urandom_range(0, 7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
      run_cmd(k, wb, 1'($urandom), $urandom, i2cmbe_pkg::KIND_TICK, 1'b1);
      repeat ($urandom_range(0, 2))
        send_item(($urandom_range(0, 3) == 0) ? 3'($urandom) : i2cmbe_pkg::KIND_TICK,
                  8'($urandom), 1'($urandom), 1'($urandom));
    end
    in_valid <= 1'b0;

    // drain, then wait out a margin before the verdict
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // guard against a hung handshake; well beyond the slowest legal run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/i2cmbe_pkg.sv
hw/rtl/i2c_master_byte_engine.sv
tb/i2c_master_byte_engine_chk.sv
tb/i2c_master_byte_engine_tb.sv
